// ----- hw/rtl/rbc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rbc_pkg
// Shared types, codes and the character classifier for the ranked bracket
// checker.
// ============================================================================
package rbc_pkg;

    // Default sizes
    localparam int STACK_DEPTH_DEF = 128;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Bracket characters
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Bracket kinds, ranked low to high
    localparam logic [1:0] KIND_PAREN = 2'd0;
    localparam logic [1:0] KIND_BRACK = 2'd1;
    localparam logic [1:0] KIND_BRACE = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_PROGRESS = 2'd0;
    localparam logic [1:0] STATUS_BALANCED = 2'd1;
    localparam logic [1:0] STATUS_INVALID  = 2'd2;

    // Operation that a character asks of the stack
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } op_t;

    // Classified word passed from front to back
    typedef struct packed {
        op_t        op;
        logic [1:0] kind;
        logic       last;
    } item_t;

    // Result word
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] open_count;
    } result_t;

    // Decode one raw byte into a stack operation
    function automatic item_t classify(input logic [7:0] c, input logic last);
        item_t it;
        it.last = last;
        it.kind = KIND_PAREN;
        it.op   = OP_NONE;
        unique case (c)
            CH_LPAREN: begin it.op = OP_OPEN;  it.kind = KIND_PAREN; end
            CH_LBRACK: begin it.op = OP_OPEN;  it.kind = KIND_BRACK; end
            CH_LBRACE: begin it.op = OP_OPEN;  it.kind = KIND_BRACE; end
            CH_RPAREN: begin it.op = OP_CLOSE; it.kind = KIND_PAREN; end
            CH_RBRACK: begin it.op = OP_CLOSE; it.kind = KIND_BRACK; end
            CH_RBRACE: begin it.op = OP_CLOSE; it.kind = KIND_BRACE; end
            default:   begin it.op = OP_NONE;  it.kind = KIND_PAREN; end
        endcase
        return it;
    endfunction

endpackage

// ----- hw/rtl/rbc_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rbc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module rbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/rbc_fifo.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rbc_fifo
// Small register queue of fixed-width words with full and empty flags.
// ============================================================================
module rbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- hw/rtl/rbc_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rbc_front
// Accepts raw characters, classifies them into stack operations and queues
// the classified words for the stack engine.
// ============================================================================
module rbc_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [7:0]     ch,
    input  logic           last_char,
    output logic           full,
    input  logic           item_pop,
    output rbc_pkg::item_t item,
    output logic           item_empty
);

    import rbc_pkg::*;

    item_t            cls;
    logic [$bits(item_t)-1:0] q_rdata;

    // Decode the byte on the way in
    assign cls = classify(ch, last_char);

    rbc_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls),
        .full  (full),
        .pop   (item_pop),
        .rdata (q_rdata),
        .empty (item_empty)
    );

    assign item = item_t'(q_rdata);

endmodule

// ----- hw/rtl/rbc_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rbc_back
// Stack engine: one classified word per cycle unless the result queue is full.
// The top kind is registered; the entry below it is prefetched from stack RAM.
// ============================================================================
module rbc_back #(
    parameter int STACK_DEPTH = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rbc_pkg::item_t   item,
    input  logic             item_empty,
    output logic             item_pop,
    output rbc_pkg::result_t result,
    output logic             result_push,
    input  logic             result_full
);

    import rbc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int HW = $clog2(STACK_DEPTH + 1);
    localparam int CW = (HW > 8) ? HW : 8;

    logic [HW-1:0] height_reg, height_next, height_new, height_eff, rd_height;
    logic          err_reg, err_next, err_new;
    logic [1:0]    top_reg, top_next;
    logic [1:0]    below;
    logic          fire, do_push, do_pop;
    logic [CW-1:0] height_ext;

    assign fire        = !item_empty && !result_full;
    assign item_pop    = fire;
    assign result_push = fire;

    // Stack decision for the word at the head of the queue
    always_comb
    begin
        do_push = 1'b0;
        do_pop  = 1'b0;
        err_new = err_reg;
        if (!err_reg)
        begin
            unique case (item.op)
                OP_OPEN:
                begin
                    if (height_reg >= HW'(STACK_DEPTH))
                    begin
                        err_new = 1'b1;
                    end
                    else if (height_reg == '0 || top_reg >= item.kind)
                    begin
                        do_push = 1'b1;
                    end
                    else
                    begin
                        err_new = 1'b1;
                    end
                end
                OP_CLOSE:
                begin
                    if (height_reg != '0 && top_reg == item.kind)
                    begin
                        do_pop = 1'b1;
                    end
                    else
                    begin
                        err_new = 1'b1;
                    end
                end
                default:
                begin
                    err_new = err_reg;
                end
            endcase
        end
    end

    assign height_new = do_push ? height_reg + 1'b1 :
                        do_pop  ? height_reg - 1'b1 : height_reg;

    // Result word, count saturates at 255
    assign height_ext = CW'(height_new);
    always_comb
    begin
        result.open_count = (height_ext > CW'(255)) ? 8'hFF : height_ext[7:0];
        if (item.last)
        begin
            result.status = (err_new || height_new != '0) ? STATUS_INVALID
                                                          : STATUS_BALANCED;
        end
        else
        begin
            result.status = err_new ? STATUS_INVALID : STATUS_PROGRESS;
        end
    end

    // Next state; end of string clears height and error
    always_comb
    begin
        height_next = height_reg;
        err_next    = err_reg;
        top_next    = top_reg;
        if (fire)
        begin
            height_next = item.last ? '0 : height_new;
            err_next    = item.last ? 1'b0 : err_new;
            if (do_push)
            begin
                top_next = item.kind;
            end
            else if (do_pop)
            begin
                top_next = below;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            height_reg <= height_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // Prefetch the entry under the next top; it meets the write only at end of string
    assign height_eff = height_next;
    assign rd_height  = height_eff - HW'(2);

    rbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (fire && do_push),
        .waddr (height_reg[AW-1:0]),
        .wdata (item.kind),
        .raddr (rd_height[AW-1:0]),
        .rdata (below)
    );

    // Checks
    a_height_bound: assert property (@(posedge clk) disable iff (!rst_n)
        height_reg <= HW'(STACK_DEPTH))
        else $error("stack height above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && do_push) |-> (height_reg < HW'(STACK_DEPTH)))
        else $error("push into full stack");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.last) |=> (height_reg == '0 && !err_reg))
        else $error("state not cleared after last character");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg && !(fire && item.last)) |=> err_reg)
        else $error("error flag dropped inside a string");

    a_err_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg && fire && !item.last) |=> $stable(height_reg))
        else $error("stack moved after an error");

endmodule

// ----- hw/rtl/ranked_bracket_checker_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ranked_bracket_checker_unit
// Ranked bracket checker: classifies characters, tracks open kinds on a
// stack and reports progress, balance or an invalid string per character.
// ============================================================================
// Path: an accepted word is written into the classified queue, then moves
//   through the stack engine into the result queue and shows on the result
//   ports (empty low).
// Throughput: one word per cycle while the result queue has room; the top
//   kind is registered and the entry below it is prefetched from stack RAM.
// Reset: height, error flag and both queues clear; stack RAM is not cleared.
module ranked_bracket_checker_unit #(
    parameter int STACK_DEPTH = rbc_pkg::STACK_DEPTH_DEF,
    parameter int QUEUE_DEPTH = rbc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] ch,
    input  logic       last_char,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] status,
    output logic [7:0] open_count
);

    import rbc_pkg::*;

    item_t   item;
    logic    item_empty, item_pop;
    result_t result;
    logic    result_push, result_full;
    logic [$bits(result_t)-1:0] out_rdata;
    result_t out_word;

    // Front: accept and classify
    rbc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .ch         (ch),
        .last_char  (last_char),
        .full       (full),
        .item_pop   (item_pop),
        .item       (item),
        .item_empty (item_empty)
    );

    // Back: stack engine
    rbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .item_empty  (item_empty),
        .item_pop    (item_pop),
        .result      (result),
        .result_push (result_push),
        .result_full (result_full)
    );

    // Result queue
    rbc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (result_push),
        .wdata (result),
        .full  (result_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign out_word   = result_t'(out_rdata);
    assign status     = out_word.status;
    assign open_count = out_word.open_count;

endmodule

// ----- tb/ranked_bracket_checker_unit_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ranked_bracket_checker_unit_test
// Self-checking bench for the ranked bracket checker. Strings of bytes go in
// through the push side and per-character verdicts come out through the pop
// side. A local bracket-stack model predicts the status and open count of
// every word. Directed strings come first, then two full-depth towers, then
// random nested strings with noise, deliberate breakage and the odd tower.
// Both sides stall at random.
// ============================================================================
module ranked_bracket_checker_unit_test;
    import rbc_pkg::*;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int CHAR_GOAL   = 1800;

    // One character word waiting to be sent
    typedef struct {
        logic [7:0] c;
        logic       fin;
        int         gap;
        bit         drain;
    } char_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] ch = 8'h00;
    logic       last_char = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] status;
    logic [7:0] open_count;

    char_word_t char_words[$];
    result_t    verdicts[$];
    int         fault_count = 0;
    int         char_total = 0;
    bit         calm = 1'b0;

    // Handshakes seen at the last rising edge
    bit char_taken = 1'b0;
    bit result_taken = 1'b0;

    // Sender state
    bit         offering = 1'b0;
    bit         gap_loaded = 1'b0;
    int         pause_left = 0;
    char_word_t cur_word;

    // Receiver state
    bit rx_drawn = 1'b0;
    bit rx_calm = 1'b0;
    int stall_left = 0;

    // Predictor state
    logic [1:0] nest_kinds [STACK_DEPTH];
    int         nest_height = 0;
    bit         nest_broken = 1'b0;

    ranked_bracket_checker_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .ch         (ch),
        .last_char  (last_char),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .open_count (open_count)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Next verdict of the bracket stack for one character
    function automatic result_t judge_char(logic [7:0] c, logic fin);
        result_t    v;
        op_t        op;
        logic [1:0] k;
        op = OP_NONE;
        k  = KIND_PAREN;
        case (c)
            CH_LPAREN: begin op = OP_OPEN;  k = KIND_PAREN; end
            CH_LBRACK: begin op = OP_OPEN;  k = KIND_BRACK; end
            CH_LBRACE: begin op = OP_OPEN;  k = KIND_BRACE; end
            CH_RPAREN: begin op = OP_CLOSE; k = KIND_PAREN; end
            CH_RBRACK: begin op = OP_CLOSE; k = KIND_BRACK; end
            CH_RBRACE: begin op = OP_CLOSE; k = KIND_BRACE; end
            default:   op = OP_NONE;
        endcase
        // Stack is frozen once the string is broken
        if (!nest_broken)
        begin
            if (op == OP_OPEN)
            begin
                if (nest_height >= STACK_DEPTH)
                    nest_broken = 1'b1;
                else if (nest_height == 0 || nest_kinds[nest_height - 1] >= k)
                begin
                    nest_kinds[nest_height] = k;
                    nest_height++;
                end
                else
                    nest_broken = 1'b1;
            end
            else if (op == OP_CLOSE)
            begin
                if (nest_height > 0 && nest_kinds[nest_height - 1] == k)
                    nest_height--;
                else
                    nest_broken = 1'b1;
            end
        end
        v.open_count = (nest_height > 255) ? 8'd255 : 8'(nest_height);
        // Verdict at end of string, then clear
        if (fin)
        begin
            v.status = (nest_broken || nest_height > 0) ? STATUS_INVALID : STATUS_BALANCED;
            nest_height = 0;
            nest_broken = 1'b0;
        end
        else
            v.status = nest_broken ? STATUS_INVALID : STATUS_PROGRESS;
        return v;
    endfunction

    function automatic logic [7:0] open_char(logic [1:0] k);
        case (k)
            KIND_PAREN: return CH_LPAREN;
            KIND_BRACK: return CH_LBRACK;
            default:    return CH_LBRACE;
        endcase
    endfunction

    function automatic logic [7:0] close_char(logic [1:0] k);
        case (k)
            KIND_PAREN: return CH_RPAREN;
            KIND_BRACK: return CH_RBRACK;
            default:    return CH_RBRACE;
        endcase
    endfunction

    task automatic add_char(logic [7:0] c, logic fin, bit drain);
        char_word_t w;
        w.c     = c;
        w.fin   = fin;
        w.gap   = calm ? 0 : $urandom_range(0, 13);
        w.drain = drain;
        char_words.push_back(w);
        char_total++;
    endtask

    // Random ranked expression with noise; may be spoiled or left open
    task automatic build_expression(int len, bit spoil, bit leave_open, bit drain);
        logic [1:0] open_kinds[$];
        logic [7:0] body[$];
        logic [1:0] top;
        logic [1:0] k;
        int         r;
        int         pos;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                body.push_back(8'($urandom_range(0, 255)));
            else if (open_kinds.size() > 0 && r < 55)
            begin
                body.push_back(close_char(open_kinds[$]));
                void'(open_kinds.pop_back());
            end
            else
            begin
                top = (open_kinds.size() > 0) ? open_kinds[$] : KIND_BRACE;
                k = 2'($urandom_range(0, top));
                open_kinds.push_back(k);
                body.push_back(open_char(k));
            end
        end
        if (!leave_open)
        begin
            while (open_kinds.size() > 0)
            begin
                body.push_back(close_char(open_kinds[$]));
                void'(open_kinds.pop_back());
            end
        end
        // Overwrite a random position with a random bracket
        if (spoil)
        begin
            pos = $urandom_range(0, body.size() - 1);
            k = 2'($urandom_range(0, 2));
            body[pos] = $urandom_range(0, 1) ? open_char(k) : close_char(k);
        end
        foreach (body[i])
            add_char(body[i], i == body.size() - 1, drain && i == 0);
    endtask

    // Full-depth tower of non-increasing kinds; optionally overflow it
    task automatic build_tower(bit overflow);
        logic [1:0] k;
        logic [1:0] kinds[$];
        k = KIND_BRACE;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            if (k != KIND_PAREN && $urandom_range(0, 40) == 0)
                k = k - 2'd1;
            kinds.push_back(k);
            add_char(open_char(k), 1'b0, 1'b0);
        end
        if (overflow)
        begin
            add_char(CH_LPAREN, 1'b0, 1'b0);
            add_char(close_char(kinds[$]), 1'b0, 1'b0);
            add_char(8'h41, 1'b1, 1'b0);
        end
        else
        begin
            while (kinds.size() > 0)
            begin
                add_char(close_char(kinds[$]), kinds.size() == 1, 1'b0);
                void'(kinds.pop_back());
            end
        end
    endtask

    // Sender: presents words at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (char_taken)
                offering = 1'b0;
            if (!offering && char_words.size() > 0)
            begin
                if (!gap_loaded)
                begin
                    pause_left = char_words[0].gap;
                    gap_loaded = 1'b1;
                end
                if (pause_left > 0)
                    pause_left--;
                else if (!(char_words[0].drain && verdicts.size() > 0))
                begin
                    cur_word = char_words.pop_front();
                    offering = 1'b1;
                    gap_loaded = 1'b0;
                end
            end
            push      <= offering;
            ch        <= cur_word.c;
            last_char <= cur_word.fin;
        end
    end

    // Receiver: random pop stalls, with calm stretches
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
                rx_drawn = 1'b0;
            if (!rx_drawn)
            begin
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                stall_left = rx_calm ? 0 : $urandom_range(0, 13);
                rx_drawn = 1'b1;
            end
            if (stall_left > 0 && !empty)
                stall_left--;
            pop <= (stall_left == 0);
        end
    end

    // Monitor: predict on accept, check on pop
    always @(posedge clk)
    begin
        result_t exp_v;
        char_taken = rst_n && push && !full;
        if (char_taken)
            verdicts.push_back(judge_char(ch, last_char));
        result_taken = rst_n && pop && !empty;
        if (result_taken)
        begin
            if (verdicts.size() == 0)
            begin
                $error("unexpected word: status %0d, open_count %0d", status, open_count);
                fault_count++;
            end
            else
            begin
                exp_v = verdicts.pop_front();
                if (status !== exp_v.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_v.status, status);
                    fault_count++;
                end
                if (open_count !== exp_v.open_count)
                begin
                    $error("open_count: expected %0d, actual %0d",
                           exp_v.open_count, open_count);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("ranked_bracket_checker_unit: mismatch");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: balanced nest using every kind
        calm = 1'b1;
        add_char(CH_LBRACE, 1'b0, 1'b0);
        add_char(CH_LBRACK, 1'b0, 1'b0);
        add_char(CH_LPAREN, 1'b0, 1'b0);
        add_char(CH_RPAREN, 1'b0, 1'b0);
        add_char(CH_RBRACK, 1'b0, 1'b0);
        add_char(CH_RBRACE, 1'b1, 1'b0);
        // Closer on empty stack, sent after a full drain
        add_char(CH_RPAREN, 1'b1, 1'b1);
        // Wrong closer, then sticky error with frozen stack
        calm = 1'b0;
        add_char(CH_LPAREN, 1'b0, 1'b0);
        add_char(CH_RBRACK, 1'b0, 1'b0);
        add_char(CH_LPAREN, 1'b1, 1'b0);
        // Opener outranks top
        add_char(CH_LPAREN, 1'b0, 1'b0);
        add_char(CH_LBRACK, 1'b0, 1'b0);
        add_char(8'h00, 1'b1, 1'b0);
        // Leftover openers at end
        add_char(CH_LBRACK, 1'b0, 1'b0);
        add_char(CH_LPAREN, 1'b1, 1'b0);
        // Only noise bytes, extremes
        add_char(8'h00, 1'b0, 1'b0);
        add_char(8'hFF, 1'b1, 1'b0);
        // Equal rank nesting
        add_char(CH_LPAREN, 1'b0, 1'b0);
        add_char(CH_LPAREN, 1'b0, 1'b0);
        add_char(CH_RPAREN, 1'b0, 1'b0);
        add_char(CH_RPAREN, 1'b1, 1'b0);

        // Full-depth strings: overflow and exact fill
        build_tower(1'b1);
        build_tower(1'b0);

        // Random strings
        while (char_total < CHAR_GOAL)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 2)
                build_tower($urandom_range(0, 1));
            else
                build_expression($urandom_range(1, 24), $urandom_range(0, 3) == 0,
                                 $urandom_range(0, 7) == 0, $urandom_range(0, 14) == 0);
        end

        // Drain
        while (char_words.size() > 0 || offering)
            @(posedge clk);
        while (verdicts.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (fault_count == 0)
            $display("ranked_bracket_checker_unit: match");
        else
            $display("ranked_bracket_checker_unit: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/rbc_pkg.sv
hw/rtl/rbc_ram.sv
hw/rtl/rbc_fifo.sv
hw/rtl/rbc_front.sv
hw/rtl/rbc_back.sv
hw/rtl/ranked_bracket_checker_unit.sv
tb/ranked_bracket_checker_unit_test.sv
